// ===== hdl/gpfl_pkg.sv =====
// ----------------------------------------------------------------------------
// gpfl_pkg
// Shared types and constants for the GPIO pin function and level block.
// ----------------------------------------------------------------------------
package gpfl_pkg;

  // Field widths of one command and one result
  localparam int CMD_W     = 2;
  localparam int PIN_W     = 6;
  localparam int CODE_W    = 8;
  localparam int LEVELS_W  = 54;
  localparam int WORD_W    = 30;
  localparam int CODE_BITS = 3;
  localparam int OFFSET_W  = 5;

  // Packed stream widths, padded to whole bytes
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 88;

  // Highest legal function code
  localparam logic [CODE_W-1:0] MAX_CODE = 8'd7;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_SET_FUNCTION = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE_LINE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ_LINE    = 2'd2;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_UPDATE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;    // register the accepted item
    logic read_word;  // read the select word of the addressed pin
    logic update;     // commit state and load the result register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;   // result register can take a new result this cycle
  } dp_status_t;

endpackage

// ===== hdl/gpfl_ctrl.sv =====
// ----------------------------------------------------------------------------
// gpfl_ctrl
// Sequencer: accept one command, fetch its select word, then commit.
// ----------------------------------------------------------------------------
module gpfl_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  gpfl_pkg::dp_status_t status,
  output gpfl_pkg::dp_cmd_t    cmd
);

  gpfl_pkg::state_t state;
  gpfl_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gpfl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    cmd           = '0;
    unique case (state)
      gpfl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = gpfl_pkg::ST_FETCH;
        end
      end
      gpfl_pkg::ST_FETCH: begin
        cmd.read_word = 1'b1;
        state_next    = gpfl_pkg::ST_UPDATE;
      end
      gpfl_pkg::ST_UPDATE: begin
        // hold until the result register frees up
        if (status.out_free) begin
          cmd.update = 1'b1;
          state_next = gpfl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = gpfl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/gpfl_datapath.sv =====
// ----------------------------------------------------------------------------
// gpfl_datapath
// Item registers, select-word memory, output latch and result register.
// ----------------------------------------------------------------------------
module gpfl_datapath #(
  parameter int PIN_COUNT            = 54,
  parameter int PINS_PER_SELECT_WORD = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [gpfl_pkg::IN_TDATA_W-1:0]     in_data,
  input  gpfl_pkg::dp_cmd_t                   cmd,
  output gpfl_pkg::dp_status_t                status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [gpfl_pkg::OUT_TDATA_W-1:0]    out_data
);

  localparam int WORD_COUNT = (PIN_COUNT + PINS_PER_SELECT_WORD - 1) / PINS_PER_SELECT_WORD;
  localparam int IDX_W      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

  // Captured item
  logic [gpfl_pkg::CMD_W-1:0]    cmd_q;
  logic [gpfl_pkg::PIN_W-1:0]    pin_q;
  logic [gpfl_pkg::CODE_W-1:0]   code_q;
  logic                          line_q;
  logic [gpfl_pkg::LEVELS_W-1:0] levels_q;

  // Select-word store and its read port
  logic [gpfl_pkg::WORD_W-1:0] sel_mem [WORD_COUNT];
  logic [WORD_COUNT-1:0]       word_valid;
  logic [gpfl_pkg::WORD_W-1:0] rd_word;
  logic                        rd_valid;

  // Output latch
  logic [PIN_COUNT-1:0] latch;
  logic [PIN_COUNT-1:0] latch_next;

  // Pin decode
  logic [IDX_W-1:0]              word_idx;
  logic [gpfl_pkg::OFFSET_W-1:0] bit_off;
  logic                          pin_ok;
  logic [63:0]                   pin_hot_wide;
  logic [63:0]                   levels_wide;
  logic [63:0]                   latch_wide;
  logic [PIN_COUNT-1:0]          pin_hot;

  // Word merge and result
  logic [gpfl_pkg::WORD_W-1:0] cur_word;
  logic [gpfl_pkg::WORD_W-1:0] field_mask;
  logic [gpfl_pkg::WORD_W-1:0] new_word;
  logic                        set_ok;
  logic                        res_error;
  logic                        res_read;
  logic [gpfl_pkg::WORD_W-1:0] res_word;

  // Result register
  logic                          out_error;
  logic                          out_read;
  logic [gpfl_pkg::WORD_W-1:0]   out_word;
  logic [gpfl_pkg::LEVELS_W-1:0] out_drive;

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q    <= in_data[1:0];
      pin_q    <= in_data[7:2];
      code_q   <= in_data[15:8];
      line_q   <= in_data[16];
      levels_q <= in_data[70:17];
    end
  end

  // Map pin number to word index and bit offset through a constant table
  always_comb begin
    word_idx = '0;
    bit_off  = '0;
    for (int k = 0; k < PIN_COUNT; k++) begin
      if (pin_q == gpfl_pkg::PIN_W'(k)) begin
        word_idx = IDX_W'(k / PINS_PER_SELECT_WORD);
        bit_off  = gpfl_pkg::OFFSET_W'((k % PINS_PER_SELECT_WORD) * gpfl_pkg::CODE_BITS);
      end
    end
  end

  assign pin_ok       = {1'b0, pin_q} < 7'(PIN_COUNT);
  assign pin_hot_wide = 64'd1 << pin_q;
  assign pin_hot      = pin_hot_wide[PIN_COUNT-1:0];
  assign levels_wide  = 64'(levels_q);
  assign latch_wide   = 64'(latch_next);

  // Read the addressed select word
  always_ff @(posedge clk) begin
    if (cmd.read_word) begin
      rd_word  <= sel_mem[word_idx];
      rd_valid <= word_valid[word_idx];
    end
  end

  // Write back the merged select word
  always_ff @(posedge clk) begin
    if (cmd.update && set_ok) begin
      sel_mem[word_idx] <= new_word;
    end
  end

  // Mark written words; unwritten words read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
    end else if (cmd.update && set_ok) begin
      word_valid[word_idx] <= 1'b1;
    end
  end

  // Merge the new function code into its field
  assign cur_word   = rd_valid ? rd_word : '0;
  assign field_mask = gpfl_pkg::WORD_W'(3'b111) << bit_off;
  assign new_word   = (cur_word & ~field_mask)
                    | (gpfl_pkg::WORD_W'(code_q[gpfl_pkg::CODE_BITS-1:0]) << bit_off);
  assign set_ok     = (cmd_q == gpfl_pkg::CMD_SET_FUNCTION) && pin_ok
                    && (code_q <= gpfl_pkg::MAX_CODE);

  // Decode the command into result fields and the next latch value
  always_comb begin
    latch_next = latch;
    res_error  = 1'b0;
    res_read   = 1'b0;
    res_word   = '0;
    unique case (cmd_q)
      gpfl_pkg::CMD_SET_FUNCTION: begin
        res_error = !set_ok;
        if (set_ok) begin
          res_word = new_word;
        end
      end
      gpfl_pkg::CMD_WRITE_LINE: begin
        res_error = !pin_ok;
        if (pin_ok) begin
          latch_next = line_q ? (latch | pin_hot) : (latch & ~pin_hot);
        end
      end
      gpfl_pkg::CMD_READ_LINE: begin
        res_error = !pin_ok;
        res_read  = pin_ok ? levels_wide[pin_q] : 1'b1;
      end
      default: begin
        res_error = 1'b1;
      end
    endcase
  end

  // Commit the output latch
  always_ff @(posedge clk) begin
    if (rst) begin
      latch <= '0;
    end else if (cmd.update) begin
      latch <= latch_next;
    end
  end

  // Result register: load on commit, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.update) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_error <= res_error;
      out_read  <= res_read;
      out_word  <= res_word;
      out_drive <= latch_wide[gpfl_pkg::LEVELS_W-1:0];
    end
  end

  assign status.out_free = !out_valid || out_ready;
  assign out_data        = {2'b00, out_drive, out_word, out_read, out_error};

endmodule

// ===== hdl/gpio_pin_function_and_level_top.sv =====
// ----------------------------------------------------------------------------
// gpio_pin_function_and_level_top
// GPIO pin function select and output latch, one command per transfer.
// ----------------------------------------------------------------------------
//
//  channel  dir  width  contents
//  s_axis   in   72     command, pin, function_code, line_value, pin_levels
//  m_axis   out  88     error, read_level, select_word, drive_levels
//
//  Each command goes through accept, select-word read and commit.
//  The select-word store has one registered read port, so the read is its own step.
//  A finished result waits in the output register; the next command is
//  accepted meanwhile and stalls at commit until the register is free.
//  Reset zeros the output latch and marks all select words as zero at once.
//
module gpio_pin_function_and_level_top #(
  parameter int PIN_COUNT            = 54,
  parameter int PINS_PER_SELECT_WORD = 10
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [1:0] command, [7:2] pin, [15:8] function_code, [16] line_value,
  // [70:17] pin_levels, [71] zero
  input  logic [gpfl_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [0] error, [1] read_level, [31:2] select_word, [85:32] drive_levels,
  // [87:86] zero
  output logic [gpfl_pkg::OUT_TDATA_W-1:0] m_tdata
);

  gpfl_pkg::dp_cmd_t    dp_cmd;
  gpfl_pkg::dp_status_t dp_status;

  gpfl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (dp_status),
    .cmd      (dp_cmd)
  );

  gpfl_datapath #(
    .PIN_COUNT            (PIN_COUNT),
    .PINS_PER_SELECT_WORD (PINS_PER_SELECT_WORD)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_tdata),
    .cmd       (dp_cmd),
    .status    (dp_status),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

// ===== hdl/gpfl_checker.sv =====
// ----------------------------------------------------------------------------
// gpfl_port_assert
// Port-level checks for the GPIO pin function and level block.
// ----------------------------------------------------------------------------
module gpfl_port_assert (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic [gpfl_pkg::IN_TDATA_W-1:0]  s_tdata,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [gpfl_pkg::OUT_TDATA_W-1:0] m_tdata
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped or changed while stalled");

  // One command at a time: no accept during fetch and commit
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
    else $error("command accepted while another is in flight");

  // Every accepted command has a result pending once it has passed fetch and commit
  a_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> ##3 m_tvalid)
    else $error("no result after accepted command");

  // A returned select word only comes with a successful command
  a_word_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[31:2] != 30'd0) |-> !m_tdata[0] && !m_tdata[1])
    else $error("select word returned with error or read level");

endmodule

bind gpio_pin_function_and_level_top gpfl_port_assert u_gpfl_port_assert (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
